// File: src/dwg_pkg.sv
// Package for the DAC waveform generator: widths, codes, CORDIC angle table.
// No dependencies.
package dwg_pkg;
    localparam int MAX_DAC_BITS_DEF = 16;
    localparam int PHASE_BITS_DEF = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W = 5;
    localparam logic [31:0] CORDIC_X0 = 32'h26DD3B6A;

    localparam logic [1:0] WAVE_SINE = 2'd0;
    localparam logic [1:0] WAVE_SQUARE = 2'd1;
    localparam logic [1:0] WAVE_SAW = 2'd2;

    localparam logic [1:0] REG_WAVE = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_BITS = 2'd2;

    typedef struct packed {
        logic [1:0]  wave;
        logic [15:0] n;
        logic [4:0]  b;
        logic [15:0] idx;
        logic        last;
    } job_t;

    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] k);
        logic [31:0] r;
        begin
            case (k)
                5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
                5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
                5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
                5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
                5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction
endpackage

// File: src/dwg_front.sv
// Front end: accepts transactions, tracks the sample index, packs the config into each job.
// Depends on dwg_pkg.
module dwg_front #(
    parameter int MAX_DAC_BITS = dwg_pkg::MAX_DAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           restart,
    input  logic [1:0]     wave_select,
    input  logic [15:0]    samples_per_period,
    input  logic [4:0]     dac_bits,
    output logic           job_valid,
    input  logic           job_ready,
    output dwg_pkg::job_t  job
);
    localparam logic [4:0] BMAX = 5'(MAX_DAC_BITS);
    logic [15:0] index_reg, index_next;
    logic [15:0] n, i;
    logic [16:0] i1;
    logic [4:0]  b;

    assign in_ready = job_ready;
    assign job_valid = in_valid;
    assign n = (samples_per_period == 16'd0) ? 16'd1 : samples_per_period;
    assign i = (restart || index_reg >= n) ? 16'd0 : index_reg;
    assign i1 = {1'b0, i} + 17'd1;
    always_comb
    begin
        b = dac_bits;
        if (b < 5'd2) b = 5'd2;
        if (b > BMAX) b = BMAX;
        index_next = (i1 >= {1'b0, n}) ? 16'd0 : i1[15:0];
        job.wave = wave_select;
        job.n = n;
        job.b = b;
        job.idx = i;
        job.last = (i1 == {1'b0, n});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            index_reg <= 16'd0;
        else if (in_valid && in_ready)
            index_reg <= index_next;
    end
endmodule

// File: src/dwg_queue.sv
// Two-entry queue between front and back end.
// Depends on dwg_pkg.
module dwg_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  dwg_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output dwg_pkg::job_t rd_data
);
    dwg_pkg::job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end
endmodule

// File: src/dwg_back.sv
// Back end: phase division, CORDIC sine, scaling; holds the result register.
// Depends on dwg_pkg.
module dwg_back #(
    parameter int MAX_DAC_BITS = dwg_pkg::MAX_DAC_BITS_DEF,
    parameter int PHASE_BITS = dwg_pkg::PHASE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  dwg_pkg::job_t job,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [15:0]   sample_code,
    output logic [15:0]   sample_index,
    output logic          period_end
);
    localparam int QW = (PHASE_BITS > MAX_DAC_BITS) ? 16 + PHASE_BITS : 16 + MAX_DAC_BITS;
    localparam int CW = MAX_DAC_BITS;
    localparam int STEP_W_L = dwg_pkg::STEP_W;
    localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_CORD = 3'd2,
                           S_MUL = 3'd3, S_CODE = 3'd4, S_OUT = 3'd5;
    localparam logic [5:0] DIV_STEPS = 6'(QW);

    logic [2:0]  state_reg;
    logic [5:0]  cnt_reg;
    dwg_pkg::job_t job_reg;
    logic [QW-1:0] quo_reg;
    logic [16:0] rem_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [1:0]  quad_reg;
    logic signed [17:0] s_reg;
    logic [47:0] prod_reg;
    logic        neg_reg;
    logic [CW-1:0] code_reg;
    logic        out_valid_reg;

    logic [17:0] rem_sh;
    logic        qbit;
    logic [QW-1:0] quo_next;
    logic signed [33:0] dx, dy, v, vr;
    logic signed [31:0] sq;
    logic [31:0] ang;
    logic [STEP_W_L-1:0] k;
    logic [CW:0] half, mask, half_in;
    logic [QW-1:0] saw_num;
    logic [47:0] pos;
    logic [CW-1:0] cres;
    logic [16:0] mag;

    assign k = cnt_reg[STEP_W_L-1:0];
    assign rem_sh = {rem_reg, quo_reg[QW-1]};
    assign qbit = (rem_sh >= {2'b0, job_reg.n});
    assign quo_next = {quo_reg[QW-2:0], qbit};
    assign dx = y_reg >>> k;
    assign dy = x_reg >>> k;
    assign ang = {quo_next[PHASE_BITS-1:0], {(32-PHASE_BITS){1'b0}}};
    assign half = (CW+1)'(1) << (job_reg.b - 5'd1);
    assign mask = ((CW+1)'(1) << job_reg.b) - (CW+1)'(1);
    assign half_in = (CW+1)'(1) << (job.b - 5'd1);
    assign saw_num = QW'(half_in - (CW+1)'(1)) * QW'(job.idx);
    assign job_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign sample_index = job_reg.idx;
    assign period_end = job_reg.last;
    assign sample_code = 16'(code_reg);

    always_comb
    begin
        unique case (quad_reg)
            2'd0: v = y_reg;
            2'd1: v = x_reg;
            2'd2: v = -y_reg;
            default: v = -x_reg;
        endcase
        vr = (v + 34'sd8192) >>> 14;
        if (vr > 34'sd65536) sq = 32'sd65536;
        else if (vr < -34'sd65536) sq = -32'sd65536;
        else sq = 32'(vr);
        mag = s_reg[17] ? 17'(-s_reg) : 17'(s_reg);
        pos = prod_reg >> 16;
        if (neg_reg)
            cres = CW'((~(CW+1)'(pos) + (CW+1)'(1)) & mask);
        else
            cres = CW'((CW+1)'(pos) & mask);
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_reg <= job;
                    if (job.wave == dwg_pkg::WAVE_SAW)
                        quo_reg <= saw_num;
                    else
                        quo_reg <= QW'({job.idx, {PHASE_BITS{1'b0}}});
                    rem_reg <= 17'd0;
                end
            end
            S_DIV:
            begin
                quo_reg <= quo_next;
                if (qbit)
                    rem_reg <= 17'(rem_sh - {2'b0, job_reg.n});
                else
                    rem_reg <= rem_sh[16:0];
                if (cnt_reg == DIV_STEPS - 6'd1)
                begin
                    x_reg <= 34'(dwg_pkg::CORDIC_X0);
                    y_reg <= 34'sd0;
                    quad_reg <= ang[31:30];
                    z_reg <= {4'b0, ang[29:0]};
                end
            end
            S_CORD:
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - 34'(dwg_pkg::atan_turn(k));
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + 34'(dwg_pkg::atan_turn(k));
                end
            end
            S_MUL:
            begin
                s_reg <= 18'(sq);
            end
            S_CODE:
            begin
                neg_reg <= s_reg[17];
                if (s_reg[17])
                    prod_reg <= 48'(half) * 48'(mag);
                else
                    prod_reg <= 48'(half - (CW+1)'(1)) * 48'(mag);
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_DIV && cnt_reg == DIV_STEPS - 6'd1)
        begin
            if (job_reg.wave == dwg_pkg::WAVE_SQUARE)
                code_reg <= ({job_reg.idx, 1'b0} <= {1'b0, job_reg.n}) ?
                            CW'(half - (CW+1)'(1)) : CW'(half);
            else if (job_reg.wave == dwg_pkg::WAVE_SAW)
                code_reg <= CW'(quo_next);
            else
                code_reg <= '0;
        end
        if (state_reg == S_OUT && !out_valid_reg && job_reg.wave == dwg_pkg::WAVE_SINE)
            code_reg <= cres;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (job_valid)
                    begin
                        state_reg <= S_DIV;
                        cnt_reg <= 6'd0;
                    end
                S_DIV:
                    if (cnt_reg == DIV_STEPS - 6'd1)
                    begin
                        cnt_reg <= 6'd0;
                        state_reg <= (job_reg.wave == dwg_pkg::WAVE_SINE) ? S_CORD : S_OUT;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                S_CORD:
                    if (cnt_reg == 6'(dwg_pkg::CORDIC_STEPS - 1))
                        state_reg <= S_MUL;
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                S_MUL:  state_reg <= S_CODE;
                S_CODE: state_reg <= S_OUT;
                S_OUT:
                    if (!out_valid_reg)
                        out_valid_reg <= 1'b1;
                    else if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: src/dac_waveform_generator_unit.sv
// DAC waveform generator top level: config registers, front end, queue, back end.
// Depends on dwg_pkg, dwg_front, dwg_queue, dwg_back.
//
// Usage: each transaction on the input channel (in_valid/in_ready, field
// restart) asks for one DAC sample; one transaction on the output channel
// (out_valid/out_ready) returns sample_code, sample_index and period_end.
// Configuration is written through cfg_we/cfg_addr/cfg_data while idle.
// The serial divider runs QW = 16 + max(PHASE_BITS, MAX_DAC_BITS) steps.
// From input acceptance to out_valid, square, sawtooth and unused-code
// requests pass through the divider only; sine requests also pass
// through 24 CORDIC iterations and scaling.
// One sample is processed at a time: the back end takes a new transaction
// only after the receiver has taken the previous result.
// The queue takes up to two further requests while the back end is busy.
// If the receiver stalls, the result holds on the output and the queue
// fills, then in_ready drops.
// Reset clears the index to zero and loads the default register values.
module dac_waveform_generator_unit #(
    parameter int MAX_DAC_BITS = dwg_pkg::MAX_DAC_BITS_DEF,
    parameter int PHASE_BITS = dwg_pkg::PHASE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] sample_code,
    output logic [15:0] sample_index,
    output logic        period_end
);
    logic [1:0]  wave_reg;
    logic [15:0] period_reg;
    logic [4:0]  bits_reg;
    logic        fv, fr, bv, br;
    dwg_pkg::job_t fj, bj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg <= dwg_pkg::WAVE_SINE;
            period_reg <= 16'd64;
            bits_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                dwg_pkg::REG_WAVE:   wave_reg <= cfg_data[1:0];
                dwg_pkg::REG_PERIOD: period_reg <= cfg_data;
                dwg_pkg::REG_BITS:   bits_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    dwg_front #(.MAX_DAC_BITS(MAX_DAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .restart(restart), .wave_select(wave_reg), .samples_per_period(period_reg),
        .dac_bits(bits_reg), .job_valid(fv), .job_ready(fr), .job(fj)
    );

    dwg_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
        .rd_valid(bv), .rd_ready(br), .rd_data(bj)
    );

    dwg_back #(.MAX_DAC_BITS(MAX_DAC_BITS), .PHASE_BITS(PHASE_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(bv), .job_ready(br), .job(bj),
        .out_valid(out_valid), .out_ready(out_ready), .sample_code(sample_code),
        .sample_index(sample_index), .period_end(period_end)
    );

`ifndef SYNTHESIS
    a_end_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && period_end |-> sample_index == (period_reg == 16'd0 ? 16'd0 :
        period_reg - 16'd1))
        else $error("period_end with wrong index");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_code))
        else $error("result changed while stalled");
`endif
endmodule

// File: bench/tb.sv
// Testbench for dac_waveform_generator_unit: directed table plus random restart requests,
// checked against an in-bench sample predictor (CORDIC sine, square, sawtooth).
// Depends on dwg_pkg and the RTL under src.
`timescale 1ns / 100ps

module tb;
    typedef struct packed {
        logic [15:0] code;
        logic [15:0] idx;
        logic        last;
    } sample_t;

    typedef struct {
        logic       rst;
        logic       has_exp;
        logic [15:0] code;
    } dir_row_t;

    localparam logic [1:0] WAVE_OFF = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        restart;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] sample_code;
    logic [15:0] sample_index;
    logic        period_end;

    dac_waveform_generator_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .restart(restart),
        .out_valid(out_valid), .out_ready(out_ready),
        .sample_code(sample_code), .sample_index(sample_index),
        .period_end(period_end)
    );

    // predictor state
    logic [1:0]  m_wave;
    logic [15:0] m_period;
    logic [4:0]  m_bits;
    logic [15:0] m_index;

    sample_t     pending_samples[$];
    int          fail_cnt;
    int          sent_cnt;
    int          got_cnt;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          cfg_cnt;

    localparam logic [31:0] ATAN_TAB [dwg_pkg::CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    function automatic longint sine_q16(input logic [15:0] ph);
        logic [31:0] ang;
        longint x, y, z, dx, dy, v, s;
        ang = {ph, 16'h0};
        x = longint'(dwg_pkg::CORDIC_X0);
        y = 0;
        z = longint'(ang[29:0]);
        for (int k = 0; k < dwg_pkg::CORDIC_STEPS; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[k]);
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[k]);
            end
        end
        case (ang[31:30])
            2'd0: v = y;
            2'd1: v = x;
            2'd2: v = -y;
            default: v = -x;
        endcase
        s = (v + 8192) >>> 14;
        if (s > 65536) s = 65536;
        if (s < -65536) s = -65536;
        return s;
    endfunction

    function automatic sample_t next_sample(input logic rst);
        sample_t r;
        longint unsigned n, b, i, half, mask, code, p;
        longint s;
        n = (m_period == 0) ? 1 : m_period;
        b = m_bits;
        if (b < 2) b = 2;
        if (b > dwg_pkg::MAX_DAC_BITS_DEF) b = dwg_pkg::MAX_DAC_BITS_DEF;
        half = 64'd1 << (b - 1);
        mask = (64'd1 << b) - 1;
        i = m_index;
        if (rst || i >= n) i = 0;
        case (m_wave)
            dwg_pkg::WAVE_SINE:
            begin
                p = (i << dwg_pkg::PHASE_BITS_DEF) / n;
                s = sine_q16(p[15:0]);
                if (s >= 0)
                    code = (((half - 1) * longint'(s)) >> 16) & mask;
                else
                    code = (64'd0 - ((half * longint'(-s)) >> 16)) & mask;
            end
            dwg_pkg::WAVE_SQUARE: code = (2 * i <= n) ? half - 1 : half;
            dwg_pkg::WAVE_SAW: code = ((half - 1) * i) / n;
            default: code = 0;
        endcase
        r.code = code[15:0];
        r.idx = i[15:0];
        r.last = (i + 1 == n);
        m_index = (i + 1 >= n) ? 16'd0 : 16'(i + 1);
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // input monitor: predicts on each accepted transaction
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            pending_samples.push_back(next_sample(restart));
            sent_cnt++;
        end
    end

    always @(posedge clk)
    begin
        sample_t e;
        if (rst_n && out_valid && out_ready)
        begin
            got_cnt++;
            if (pending_samples.size() == 0)
            begin
                $error("unexpected transaction: code %0h index %0d",
                       sample_code, sample_index);
                fail_cnt++;
            end
            else
            begin
                e = pending_samples.pop_front();
                if (sample_code !== e.code)
                begin
                    $error("sample_code exp %0h got %0h", e.code, sample_code);
                    fail_cnt++;
                end
                if (sample_index !== e.idx)
                begin
                    $error("sample_index exp %0d got %0d", e.idx, sample_index);
                    fail_cnt++;
                end
                if (period_end !== e.last)
                begin
                    $error("period_end exp %0b got %0b", e.last, period_end);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("timeout");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(input logic [1:0] addr, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (addr)
            dwg_pkg::REG_WAVE: m_wave = val[1:0];
            dwg_pkg::REG_PERIOD: m_period = val;
            dwg_pkg::REG_BITS: m_bits = val[4:0];
            default: ;
        endcase
        cfg_cnt++;
    endtask

    task automatic drain_all();
        while (pending_samples.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic send_request(input logic rst);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid <= 1'b1;
        restart <= rst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [1:0] w, input logic [15:0] n,
                              input logic [4:0] b);
        drain_all();
        write_reg(dwg_pkg::REG_WAVE, {14'd0, w});
        write_reg(dwg_pkg::REG_PERIOD, n);
        write_reg(dwg_pkg::REG_BITS, {11'd0, b});
    endtask

    dir_row_t dir_rows [5];

    initial
    begin
        sample_t head;
        int      phase;
        int      burst;
        logic [15:0] n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = dwg_pkg::REG_WAVE;
        cfg_data = 16'd0;
        in_valid = 1'b0;
        restart = 1'b0;
        fail_cnt = 0;
        sent_cnt = 0;
        got_cnt = 0;
        idle_cycles = 0;
        cfg_cnt = 0;
        send_idle_pct = 10;
        recv_idle_pct = 54;
        m_wave = dwg_pkg::WAVE_SINE;
        m_period = 16'd64;
        m_bits = 5'd16;
        m_index = 16'd0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: defaults, sine at index 0 is code 0; then square/saw extremes
        dir_rows = '{
            '{1'b0, 1'b1, 16'h0000}, '{1'b0, 1'b0, 16'h0}, '{1'b1, 1'b1, 16'h0000},
            '{1'b0, 1'b0, 16'h0}, '{1'b0, 1'b0, 16'h0}
        };
        foreach (dir_rows[r])
        begin
            send_request(dir_rows[r].rst);
            if (dir_rows[r].has_exp && pending_samples.size() > 0)
            begin
                head = pending_samples[pending_samples.size() - 1];
                if (head.code !== dir_rows[r].code)
                begin
                    $error("sample_code table exp %0h pred %0h", dir_rows[r].code, head.code);
                    fail_cnt++;
                end
            end
        end
        // square at 16 bits starts at +max, period 1 always sample 0
        set_config(dwg_pkg::WAVE_SQUARE, 16'd1, 5'd16);
        send_request(1'b0);
        send_request(1'b0);
        set_config(dwg_pkg::WAVE_SAW, 16'd0, 5'd0);
        send_request(1'b0);
        set_config(dwg_pkg::WAVE_SAW, 16'hFFFF, 5'd31);
        for (int k = 0; k < 3; k++) send_request(k == 2);
        set_config(WAVE_OFF, 16'd5, 5'd2);
        for (int k = 0; k < 6; k++) send_request(1'b0);
        set_config(dwg_pkg::WAVE_SINE, 16'd4, 5'd2);
        for (int k = 0; k < 5; k++) send_request(1'b0);
        // lowered period below current index
        set_config(dwg_pkg::WAVE_SINE, 16'd40, 5'd12);
        for (int k = 0; k < 30; k++) send_request(1'b0);
        drain_all();
        write_reg(dwg_pkg::REG_PERIOD, 16'd7);
        send_request(1'b0);

        // random phases
        for (phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 10;
            end
            if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (burst = 0; burst < 10; burst++)
            begin
                n = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 48));
                set_config(2'($urandom_range(3)), n, 5'($urandom));
                if (burst == 5) drain_all();
                for (int k = 0; k < 30; k++)
                    send_request($urandom_range(19) == 0);
            end
        end

        drain_all();
        $display("covered %0d requests, %0d results, %0d register writes",
                 sent_cnt, got_cnt, cfg_cnt);
        $display("all waveforms, period and resolution extremes, restart and wrap cases");
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: dac_waveform_generator_unit.f
src/dwg_pkg.sv
src/dwg_front.sv
src/dwg_queue.sv
src/dwg_back.sv
src/dac_waveform_generator_unit.sv
bench/tb.sv
